FILE: rtl/core/pts_pkg.sv
// Shared types and constants for the pan/tilt servo controller.
`default_nettype none

package pts_pkg;

  // Default widths of the joystick samples and the image coordinates
  localparam int JOY_BITS_DEF   = 12;
  localparam int COORD_BITS_DEF = 10;

  // Configuration register widths
  localparam int TARGET_W   = 10;
  localparam int GAIN_W     = 16;
  localparam int DB_W       = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Servo pulse values
  localparam int PULSE_W    = 9;
  localparam int PULSE_HOME = 307;
  localparam int AUTO_MIN   = 192;
  localparam int AUTO_MAX   = 420;
  localparam int MAN_MIN    = 192;
  localparam int MAN_MAX    = 422;

  // Gains are Q0.16 applied to a doubled error, hence 17 fraction bits
  localparam int FRAC_SHIFT = 17;

  // Joystick dead zone and scaling
  localparam int DZ_LOW     = 2000;
  localparam int DZ_HIGH    = 2150;
  localparam int JOY_CENTRE = 2048;
  localparam int JOY_IDLE   = 2100;
  localparam int JOY_STEP   = 20;
  localparam int JOY_SHIFT  = 12;
  localparam int JOY_MIN_W  = 12;

  // Widest doubled error (16-bit coordinates) and the gain product over it
  localparam int E2_MAX_W = 19;
  localparam int PROD_W   = GAIN_W + 1 + E2_MAX_W;
  // Per-tick joystick step, sized for 16-bit samples
  localparam int STEP_W   = 11;

  // Register reset values
  localparam logic [TARGET_W-1:0] AIM_X_RST     = TARGET_W'(170);
  localparam logic [TARGET_W-1:0] AIM_Y_RST     = TARGET_W'(150);
  localparam logic [GAIN_W-1:0]   PAN_GAIN_RST  = GAIN_W'(3932);
  localparam logic [GAIN_W-1:0]   TILT_GAIN_RST = GAIN_W'(3277);
  localparam logic [DB_W-1:0]     DEADBAND_RST  = DB_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AIM_X     = 3'd0,
    CFG_AIM_Y     = 3'd1,
    CFG_PAN_GAIN  = 3'd2,
    CFG_TILT_GAIN = 3'd3,
    CFG_DEADBAND  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [TARGET_W-1:0] aim_x;
    logic [TARGET_W-1:0] aim_y;
    logic [GAIN_W-1:0]   pan_gain;
    logic [GAIN_W-1:0]   tilt_gain;
    logic [DB_W-1:0]     error_deadband;
  } cfg_t;

  // Per-item motion request handed to the state update
  typedef struct packed {
    logic                      auto_mode;
    logic                      upd_pan;
    logic                      upd_tilt;
    logic signed [PROD_W-1:0]  pan_prod;
    logic signed [PROD_W-1:0]  tilt_prod;
    logic signed [STEP_W-1:0]  pan_step;
    logic signed [STEP_W-1:0]  tilt_step;
  } delta_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pan_pulse;
    logic [PULSE_W-1:0] tilt_pulse;
    logic               pan_write;
    logic               tilt_write;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/pts_ifs.sv
// Handshake channel interfaces: control tick items in, servo result items out.
`default_nettype none

interface pts_tick_if #(
  parameter int JOY_BITS   = pts_pkg::JOY_BITS_DEF,
  parameter int COORD_BITS = pts_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  auto_mode;
  logic                  joy_valid;
  logic [JOY_BITS-1:0]   joy_x;
  logic [JOY_BITS-1:0]   joy_y;
  logic                  face_valid;
  logic [COORD_BITS-1:0] face_x;
  logic [COORD_BITS-1:0] face_y;
  logic [COORD_BITS-1:0] face_w;
  logic [COORD_BITS-1:0] face_h;

  modport source (
    output valid, auto_mode, joy_valid, joy_x, joy_y,
           face_valid, face_x, face_y, face_w, face_h,
    input  ready
  );
  modport sink (
    input  valid, auto_mode, joy_valid, joy_x, joy_y,
           face_valid, face_x, face_y, face_w, face_h,
    output ready
  );
endinterface

interface pts_servo_if;
  logic                        valid;
  logic                        ready;
  logic [pts_pkg::PULSE_W-1:0] pan_pulse;
  logic [pts_pkg::PULSE_W-1:0] tilt_pulse;
  logic                        pan_write;
  logic                        tilt_write;

  modport source (
    output valid, pan_pulse, tilt_pulse, pan_write, tilt_write,
    input  ready
  );
  modport sink (
    input  valid, pan_pulse, tilt_pulse, pan_write, tilt_write,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/pts_delta.sv
// Stateless front end: face errors, deadband test, gain products, joystick steps.
`default_nettype none

module pts_delta #(
  parameter int JOY_BITS   = pts_pkg::JOY_BITS_DEF,
  parameter int COORD_BITS = pts_pkg::COORD_BITS_DEF
) (
  input  pts_pkg::cfg_t          cfg,
  input  logic                   auto_mode,
  input  logic                   joy_valid,
  input  logic [JOY_BITS-1:0]    joy_x,
  input  logic [JOY_BITS-1:0]    joy_y,
  input  logic                   face_valid,
  input  logic [COORD_BITS-1:0]  face_x,
  input  logic [COORD_BITS-1:0]  face_y,
  input  logic [COORD_BITS-1:0]  face_w,
  input  logic [COORD_BITS-1:0]  face_h,
  output pts_pkg::delta_t        delta
);

  // Coordinate width covering both the box fields and the targets
  localparam int CW = (COORD_BITS > pts_pkg::TARGET_W) ? COORD_BITS : pts_pkg::TARGET_W;
  localparam int EW = CW + 3;
  localparam int PPW = pts_pkg::GAIN_W + 1 + EW;
  // Joystick sample width covering the dead zone constants
  localparam int AW = (JOY_BITS > pts_pkg::JOY_MIN_W) ? JOY_BITS : pts_pkg::JOY_MIN_W;
  localparam int SW = AW + 6;

  logic [CW-1:0]           tx, ty, fx, fy, fw, fh;
  logic signed [EW-1:0]    ex, ey;
  logic [EW-1:0]           mx, my;
  logic                    over_x, over_y;
  logic signed [PPW-1:0]   pp_pan, pp_tilt;
  logic [AW-1:0]           ax, ay;
  logic                    dz_x, dz_y;
  logic signed [AW:0]      dx, dy;
  logic signed [SW-1:0]    sx, sy;
  logic signed [SW-1:0]    nsy;

  always_comb begin
    tx = CW'(cfg.aim_x);
    ty = CW'(cfg.aim_y);
    fx = CW'(face_x);
    fy = CW'(face_y);
    fw = CW'(face_w);
    fh = CW'(face_h);

    // Doubled error: 2*target - 2*left - width
    ex = $signed({2'b00, tx, 1'b0}) - $signed({2'b00, fx, 1'b0}) - $signed({3'b000, fw});
    ey = $signed({2'b00, ty, 1'b0}) - $signed({2'b00, fy, 1'b0}) - $signed({3'b000, fh});
    mx = ex[EW-1] ? EW'(-ex) : EW'(ex);
    my = ey[EW-1] ? EW'(-ey) : EW'(ey);
    over_x = (mx >> 1) > EW'(cfg.error_deadband);
    over_y = (my >> 1) > EW'(cfg.error_deadband);

    pp_pan  = $signed({1'b0, cfg.pan_gain}) * ex;
    pp_tilt = $signed({1'b0, cfg.tilt_gain}) * ey;

    // Missing joystick sample reads as inside the dead zone
    ax = joy_valid ? AW'(joy_x) : AW'(pts_pkg::JOY_IDLE);
    ay = joy_valid ? AW'(joy_y) : AW'(pts_pkg::JOY_IDLE);
    dz_x = (ax > AW'(pts_pkg::DZ_LOW)) && (ax < AW'(pts_pkg::DZ_HIGH));
    dz_y = (ay > AW'(pts_pkg::DZ_LOW)) && (ay < AW'(pts_pkg::DZ_HIGH));
    dx = $signed({1'b0, ax}) - $signed((AW+1)'(pts_pkg::JOY_CENTRE));
    dy = $signed({1'b0, ay}) - $signed((AW+1)'(pts_pkg::JOY_CENTRE));
    sx = SW'(dx) * $signed(SW'(pts_pkg::JOY_STEP));
    sy = SW'(dy) * $signed(SW'(pts_pkg::JOY_STEP));
    nsy = -sy;

    delta.auto_mode = auto_mode;
    delta.upd_pan   = face_valid && over_x;
    delta.upd_tilt  = face_valid && over_y;
    delta.pan_prod  = pts_pkg::PROD_W'(pp_pan);
    delta.tilt_prod = pts_pkg::PROD_W'(pp_tilt);
    // Arithmetic shift floors the divide by 4096
    delta.pan_step  = dz_x ? '0 :
                      pts_pkg::STEP_W'($signed(sx[SW-1:pts_pkg::JOY_SHIFT]));
    delta.tilt_step = dz_y ? '0 :
                      pts_pkg::STEP_W'($signed(nsy[SW-1:pts_pkg::JOY_SHIFT]));
  end

endmodule

`default_nettype wire

FILE: rtl/core/pts_state.sv
// Servo position state, clamped update and write-flag result register.
`default_nettype none

module pts_state (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  pts_pkg::delta_t  delta,
  output pts_pkg::result_t result
);

  localparam int PW    = pts_pkg::PULSE_W;
  localparam int FS    = pts_pkg::FRAC_SHIFT;
  localparam int SUM_W = pts_pkg::PROD_W + 2;
  localparam int MAN_W = pts_pkg::STEP_W + 1;
  localparam logic signed [SUM_W-1:0] ACC_LO = SUM_W'(pts_pkg::AUTO_MIN) <<< FS;
  localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'(pts_pkg::AUTO_MAX) <<< FS;

  logic [PW-1:0] pan, tilt, last_pan, last_tilt;
  logic [PW-1:0] pan_next, tilt_next, last_pan_next, last_tilt_next;
  logic          pan_write_next, tilt_write_next;

  logic signed [SUM_W-1:0] pan_acc, tilt_acc;
  logic signed [MAN_W-1:0] pan_man, tilt_man;
  logic [PW-1:0]           pan_auto, tilt_auto, pan_mclip, tilt_mclip;

  function automatic logic [PW-1:0] clip_auto(input logic signed [SUM_W-1:0] acc);
    logic [PW-1:0] r;
    if (acc < ACC_LO) begin
      r = PW'(pts_pkg::AUTO_MIN);
    end else if (acc > ACC_HI) begin
      r = PW'(pts_pkg::AUTO_MAX);
    end else begin
      r = acc[PW+FS-1:FS];
    end
    return r;
  endfunction

  function automatic logic [PW-1:0] clip_man(input logic signed [MAN_W-1:0] v);
    logic [PW-1:0] r;
    if (v < $signed(MAN_W'(pts_pkg::MAN_MIN))) begin
      r = PW'(pts_pkg::MAN_MIN);
    end else if (v > $signed(MAN_W'(pts_pkg::MAN_MAX))) begin
      r = PW'(pts_pkg::MAN_MAX);
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    pan_acc  = $signed({{(SUM_W-PW-FS){1'b0}}, pan, {FS{1'b0}}}) - SUM_W'(delta.pan_prod);
    tilt_acc = $signed({{(SUM_W-PW-FS){1'b0}}, tilt, {FS{1'b0}}}) + SUM_W'(delta.tilt_prod);
    pan_auto  = clip_auto(pan_acc);
    tilt_auto = clip_auto(tilt_acc);

    pan_man  = $signed({{(MAN_W-PW){1'b0}}, pan}) + MAN_W'(delta.pan_step);
    tilt_man = $signed({{(MAN_W-PW){1'b0}}, tilt}) + MAN_W'(delta.tilt_step);
    pan_mclip  = clip_man(pan_man);
    tilt_mclip = clip_man(tilt_man);

    pan_next        = pan;
    tilt_next       = tilt;
    last_pan_next   = last_pan;
    last_tilt_next  = last_tilt;
    pan_write_next  = 1'b0;
    tilt_write_next = 1'b0;
    if (delta.auto_mode) begin
      if (delta.upd_pan) begin
        pan_next       = pan_auto;
        pan_write_next = 1'b1;
      end
      if (delta.upd_tilt) begin
        tilt_next       = tilt_auto;
        tilt_write_next = 1'b1;
      end
    end else begin
      pan_next        = pan_mclip;
      tilt_next       = tilt_mclip;
      pan_write_next  = pan_mclip != last_pan;
      tilt_write_next = tilt_mclip != last_tilt;
      last_pan_next   = pan_mclip;
      last_tilt_next  = tilt_mclip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pan       <= PW'(pts_pkg::PULSE_HOME);
      tilt      <= PW'(pts_pkg::PULSE_HOME);
      last_pan  <= '0;
      last_tilt <= '0;
    end else if (adv) begin
      pan       <= pan_next;
      tilt      <= tilt_next;
      last_pan  <= last_pan_next;
      last_tilt <= last_tilt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.pan_pulse  <= pan_next;
      result.tilt_pulse <= tilt_next;
      result.pan_write  <= pan_write_next;
      result.tilt_write <= tilt_write_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pan_tilt_servo_controller.sv
// Pan/tilt servo controller top level: config registers and three-stage item pipeline.
// Items pass the input register, gain-product register and state/result register.
// Throughput: one item per cycle while the servo side is ready; the state updates
//   in the last stage with no bubble.
// Reset (rst, synchronous): pipeline empty, config to defaults, servos at 307,
//   manual-history values at zero.
`default_nettype none

module pan_tilt_servo_controller #(
  parameter int JOY_BITS   = pts_pkg::JOY_BITS_DEF,
  parameter int COORD_BITS = pts_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]     cfg_data,
  pts_tick_if.sink                           tick,
  pts_servo_if.source                        servo
);

  // Configuration registers; the user must write them only while no item is in flight (not enforced)
  pts_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aim_x          <= pts_pkg::AIM_X_RST;
      cfg.aim_y          <= pts_pkg::AIM_Y_RST;
      cfg.pan_gain       <= pts_pkg::PAN_GAIN_RST;
      cfg.tilt_gain      <= pts_pkg::TILT_GAIN_RST;
      cfg.error_deadband <= pts_pkg::DEADBAND_RST;
    end else if (cfg_we) begin
      case (pts_pkg::cfg_idx_t'(cfg_index))
        pts_pkg::CFG_AIM_X:     cfg.aim_x          <= cfg_data[pts_pkg::TARGET_W-1:0];
        pts_pkg::CFG_AIM_Y:     cfg.aim_y          <= cfg_data[pts_pkg::TARGET_W-1:0];
        pts_pkg::CFG_PAN_GAIN:  cfg.pan_gain       <= cfg_data[pts_pkg::GAIN_W-1:0];
        pts_pkg::CFG_TILT_GAIN: cfg.tilt_gain      <= cfg_data[pts_pkg::GAIN_W-1:0];
        pts_pkg::CFG_DEADBAND:  cfg.error_deadband <= cfg_data[pts_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: each stage moves when the next one is empty or moving.
  // The output register acts as the skid stage toward the servo side.
  logic s1_valid, s2_valid, s3_valid;
  logic adv1, adv2, adv3;

  assign adv3 = s2_valid && (!s3_valid || servo.ready);
  assign adv2 = s1_valid && (!s2_valid || adv3);
  assign tick.ready = !s1_valid || adv2;
  assign adv1 = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= 1'b1;
      end else if (adv2) begin
        s1_valid <= 1'b0;
      end
      if (adv2) begin
        s2_valid <= 1'b1;
      end else if (adv3) begin
        s2_valid <= 1'b0;
      end
      if (adv3) begin
        s3_valid <= 1'b1;
      end else if (servo.ready) begin
        s3_valid <= 1'b0;
      end
    end
  end

  // Stage 1: input item register
  logic                  s1_auto_mode, s1_joy_valid, s1_face_valid;
  logic [JOY_BITS-1:0]   s1_joy_x, s1_joy_y;
  logic [COORD_BITS-1:0] s1_face_x, s1_face_y, s1_face_w, s1_face_h;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_auto_mode  <= tick.auto_mode;
      s1_joy_valid  <= tick.joy_valid;
      s1_joy_x      <= tick.joy_x;
      s1_joy_y      <= tick.joy_y;
      s1_face_valid <= tick.face_valid;
      s1_face_x     <= tick.face_x;
      s1_face_y     <= tick.face_y;
      s1_face_w     <= tick.face_w;
      s1_face_h     <= tick.face_h;
    end
  end

  // Stage 2: errors, deadband decision, gain products and joystick steps.
  // None of it depends on servo state, so it runs ahead of the update.
  pts_pkg::delta_t delta, s2_delta;

  pts_delta #(
    .JOY_BITS   (JOY_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_delta (
    .cfg        (cfg),
    .auto_mode  (s1_auto_mode),
    .joy_valid  (s1_joy_valid),
    .joy_x      (s1_joy_x),
    .joy_y      (s1_joy_y),
    .face_valid (s1_face_valid),
    .face_x     (s1_face_x),
    .face_y     (s1_face_y),
    .face_w     (s1_face_w),
    .face_h     (s1_face_h),
    .delta      (delta)
  );

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_delta <= delta;
    end
  end

  // Stage 3: add, clamp, write flags; state and result register together
  pts_pkg::result_t result;

  pts_state u_state (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv3),
    .delta  (s2_delta),
    .result (result)
  );

  assign servo.valid      = s3_valid;
  assign servo.pan_pulse  = result.pan_pulse;
  assign servo.tilt_pulse = result.tilt_pulse;
  assign servo.pan_write  = result.pan_write;
  assign servo.tilt_write = result.tilt_write;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the pan/tilt servo controller: directed, sweep and random ticks.
`timescale 1ns / 1ps

module tb_top;

  localparam int JW = pts_pkg::JOY_BITS_DEF;
  localparam int CW = pts_pkg::COORD_BITS_DEF;
  localparam int PW = pts_pkg::PULSE_W;

  // One control tick as the sender builds it
  typedef struct packed {
    logic          auto_mode;
    logic          joy_valid;
    logic [JW-1:0] joy_x;
    logic [JW-1:0] joy_y;
    logic          face_valid;
    logic [CW-1:0] face_x;
    logic [CW-1:0] face_y;
    logic [CW-1:0] face_w;
    logic [CW-1:0] face_h;
  } tick_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pts_pkg::CFG_DATA_W-1:0] cfg_data;

  pts_tick_if  tick_ch ();
  pts_servo_if servo_ch ();

  pan_tilt_servo_controller uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .servo     (servo_ch)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: register copy and servo state, updated once per accepted item
  // ---------------------------------------------------------------------------
  logic [pts_pkg::TARGET_W-1:0] aim_x, aim_y;
  logic [pts_pkg::GAIN_W-1:0]   pan_gain_r, tilt_gain_r;
  logic [pts_pkg::DB_W-1:0]     deadband_r;
  logic [PW-1:0]                pan_now, tilt_now, pan_last_man, tilt_last_man;

  pts_pkg::result_t pending_pulses[$];   // expected results, oldest first
  pts_pkg::result_t want;
  int               mismatches = 0;
  bit               steady = 1'b0;       // set: neither side idles

  // Proportional step in 17 fraction bits, clamped to the tracking range
  function automatic logic [PW-1:0] auto_pulse(input logic [PW-1:0] v,
                                               input logic [pts_pkg::GAIN_W-1:0] g,
                                               input longint e2, input bit add);
    longint acc, d, lo, hi;
    acc = longint'(v) <<< pts_pkg::FRAC_SHIFT;
    d   = longint'(g) * e2;
    lo  = longint'(pts_pkg::AUTO_MIN) <<< pts_pkg::FRAC_SHIFT;
    hi  = longint'(pts_pkg::AUTO_MAX) <<< pts_pkg::FRAC_SHIFT;
    acc = add ? acc + d : acc - d;
    if (acc < lo) acc = lo;
    if (acc > hi) acc = hi;
    return PW'(acc >>> pts_pkg::FRAC_SHIFT);
  endfunction

  // Joystick nudge: zero inside the dead zone, else floor(+-20*(a-2048)/4096)
  function automatic int joy_delta(input int a, input bit invert);
    int num;
    if (a > pts_pkg::DZ_LOW && a < pts_pkg::DZ_HIGH) return 0;
    num = pts_pkg::JOY_STEP * (a - pts_pkg::JOY_CENTRE);
    if (invert) num = -num;
    return num >>> pts_pkg::JOY_SHIFT;   // arithmetic shift floors
  endfunction

  function automatic logic [PW-1:0] man_clamp(input int v);
    if (v < pts_pkg::MAN_MIN) return PW'(pts_pkg::MAN_MIN);
    if (v > pts_pkg::MAN_MAX) return PW'(pts_pkg::MAN_MAX);
    return PW'(v);
  endfunction

  function automatic pts_pkg::result_t advance_servos(input tick_t t);
    pts_pkg::result_t r;
    longint           ex, ey;
    int               jx, jy;
    r.pan_write  = 1'b0;
    r.tilt_write = 1'b0;
    if (t.auto_mode) begin
      if (t.face_valid) begin
        // doubled error keeps the half unit of the box centre
        ex = 2 * longint'(aim_x) - 2 * longint'(t.face_x) - longint'(t.face_w);
        ey = 2 * longint'(aim_y) - 2 * longint'(t.face_y) - longint'(t.face_h);
        if ((ex < 0 ? -ex : ex) / 2 > longint'(deadband_r)) begin
          pan_now     = auto_pulse(pan_now, pan_gain_r, ex, 1'b0);
          r.pan_write = 1'b1;
        end
        if ((ey < 0 ? -ey : ey) / 2 > longint'(deadband_r)) begin
          tilt_now     = auto_pulse(tilt_now, tilt_gain_r, ey, 1'b1);
          r.tilt_write = 1'b1;
        end
      end
    end else begin
      jx = t.joy_valid ? int'(t.joy_x) : pts_pkg::JOY_IDLE;
      jy = t.joy_valid ? int'(t.joy_y) : pts_pkg::JOY_IDLE;
      pan_now  = man_clamp(int'(pan_now) + joy_delta(jx, 1'b0));
      tilt_now = man_clamp(int'(tilt_now) + joy_delta(jy, 1'b1));
      // flags compare against the previous manual tick, not the previous tick
      r.pan_write   = (pan_now != pan_last_man);
      r.tilt_write  = (tilt_now != tilt_last_man);
      pan_last_man  = pan_now;
      tilt_last_man = tilt_now;
    end
    r.pan_pulse  = pan_now;
    r.tilt_pulse = tilt_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Idling: mostly none, sometimes a short gap, now and then a long gap
  // ---------------------------------------------------------------------------
  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Tick sender; entered and left at a falling edge, valid left high
  // ---------------------------------------------------------------------------
  task automatic send_tick(input tick_t t);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      tick_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid      = 1'b1;
    tick_ch.auto_mode  = t.auto_mode;
    tick_ch.joy_valid  = t.joy_valid;
    tick_ch.joy_x      = t.joy_x;
    tick_ch.joy_y      = t.joy_y;
    tick_ch.face_valid = t.face_valid;
    tick_ch.face_x     = t.face_x;
    tick_ch.face_y     = t.face_y;
    tick_ch.face_w     = t.face_w;
    tick_ch.face_h     = t.face_h;
    do @(posedge clk); while (!tick_ch.ready);
    pending_pulses.push_back(advance_servos(t));
    @(negedge clk);
  endtask

  // Stop sending and let every expected result arrive, then let the
  // three-stage pipeline run dry before anything is reconfigured.
  task automatic wait_drained();
    tick_ch.valid = 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input pts_pkg::cfg_idx_t idx,
                           input logic [pts_pkg::CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      pts_pkg::CFG_AIM_X:     aim_x       = data[pts_pkg::TARGET_W-1:0];
      pts_pkg::CFG_AIM_Y:     aim_y       = data[pts_pkg::TARGET_W-1:0];
      pts_pkg::CFG_PAN_GAIN:  pan_gain_r  = data[pts_pkg::GAIN_W-1:0];
      pts_pkg::CFG_TILT_GAIN: tilt_gain_r = data[pts_pkg::GAIN_W-1:0];
      pts_pkg::CFG_DEADBAND:  deadband_r  = data[pts_pkg::DB_W-1:0];
      default: ;
    endcase
  endtask

  // Full register set; unused high data bits carry junk the block must drop
  task automatic apply_settings(input int tx, input int ty, input int pg, input int tg,
                                input int db);
    wait_drained();
    write_reg(pts_pkg::CFG_AIM_X,     {6'($urandom), 10'(tx)});
    write_reg(pts_pkg::CFG_AIM_Y,     {6'($urandom), 10'(ty)});
    write_reg(pts_pkg::CFG_PAN_GAIN,  16'(pg));
    write_reg(pts_pkg::CFG_TILT_GAIN, 16'(tg));
    write_reg(pts_pkg::CFG_DEADBAND,  {8'($urandom), 8'(db)});
  endtask

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic tick_t face_tick(input int fx, input int fy, input int fw, input int fh);
    tick_t t;
    t            = tick_t'({$urandom, $urandom, $urandom});
    t.auto_mode  = 1'b1;
    t.face_valid = 1'b1;
    t.face_x     = CW'(fx);
    t.face_y     = CW'(fy);
    t.face_w     = CW'(fw);
    t.face_h     = CW'(fh);
    return t;
  endfunction

  function automatic tick_t joy_tick(input bit jv, input int jx, input int jy);
    tick_t t;
    t           = tick_t'({$urandom, $urandom, $urandom});
    t.auto_mode = 1'b0;
    t.joy_valid = jv;
    t.joy_x     = JW'(jx);
    t.joy_y     = JW'(jy);
    return t;
  endfunction

  // Box edge that puts the box centre close to the target
  function automatic logic [CW-1:0] coord_near(input logic [CW-1:0] aim,
                                               input logic [CW-1:0] size);
    int c;
    c = int'(aim) - int'(size) / 2 + int'($urandom_range(0, 60)) - 30;
    if (c < 0) c = 0;
    if (c > 1023) c = 1023;
    return CW'(c);
  endfunction

  // lean 1 pushes toward high samples, lean 2 toward low ones
  function automatic logic [JW-1:0] joy_sample(input int lean);
    int r;
    r = $urandom_range(0, 9);
    if (lean == 1 && r < 4) return JW'($urandom_range(3500, 4095));
    if (lean == 2 && r < 4) return JW'($urandom_range(0, 500));
    if (r < 6) return JW'($urandom_range(1995, 2155));
    if (r < 7) return ($urandom_range(0, 1) != 0) ? JW'(4095) : JW'(0);
    return JW'($urandom);
  endfunction

  function automatic tick_t rand_tick(input int lean);
    tick_t t;
    int    pick;
    t    = tick_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // face tracking, often near the target so the deadband edge is hit
      t.auto_mode  = 1'b1;
      t.face_valid = 1'b1;
      if ($urandom_range(0, 2) != 0) begin
        t.face_w = CW'($urandom_range(0, 300));
        t.face_h = CW'($urandom_range(0, 300));
        t.face_x = coord_near(aim_x, t.face_w);
        t.face_y = coord_near(aim_y, t.face_h);
      end
    end else if (pick < 88) begin
      t.auto_mode = 1'b0;
      t.joy_valid = 1'b1;
      t.joy_x     = joy_sample(lean);
      t.joy_y     = joy_sample(lean);
    end else if (pick < 94) begin
      t.auto_mode  = 1'b1;   // no face this tick
      t.face_valid = 1'b0;
    end else begin
      t.auto_mode = 1'b0;    // joystick missing, reads as centred
      t.joy_valid = 1'b0;
    end
    return t;
  endfunction

  task automatic run_random(input int n, input int lean);
    repeat (n) send_tick(rand_tick(lean));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: box extremes, missing joystick, dead zone edges
  task automatic test_joystick_edges();
    send_tick(face_tick(1023, 1023, 1023, 1023));
    send_tick(face_tick(0, 0, 0, 0));
    tick_ch.valid = 1'b1;
    send_tick(joy_tick(1'b0, 0, 4095));      // missing: both flags set vs zero history
    send_tick(joy_tick(1'b1, 2048, 2048));   // centred: no change, no flags
    send_tick(joy_tick(1'b1, 0, 0));         // full low
    send_tick(joy_tick(1'b1, 4095, 4095));   // full high
    send_tick(joy_tick(1'b1, 2000, 2150));   // just outside the dead zone
    send_tick(joy_tick(1'b1, 2001, 2149));   // just inside
  endtask

  // Deadband boundary on both axes, odd and even doubled errors, box extremes
  task automatic test_face_deadband();
    send_tick(face_tick(161, 141, 0, 0));      // error 9: both move
    send_tick(face_tick(162, 142, 0, 1));      // error 8 and 7: hold
    send_tick(face_tick(170, 150, 17, 18));    // -8 holds, -9 moves
    send_tick(face_tick(0, 0, 0, 0));
    send_tick(face_tick(1023, 1023, 1023, 1023));
    send_tick(joy_tick(1'b1, 2048, 2048));     // manual flags after auto motion
  endtask

  // Full gains drive both axes into the tracking clamps, then manual clamps
  task automatic test_clamps();
    apply_settings(170, 150, 65535, 65535, 0);
    send_tick(face_tick(0, 0, 0, 0));
    send_tick(face_tick(0, 0, 0, 0));
    send_tick(joy_tick(1'b1, 0, 0));           // pan below 192, tilt above 422
    send_tick(face_tick(1023, 1023, 1023, 1023));
    send_tick(face_tick(1023, 1023, 1023, 1023));
    send_tick(joy_tick(1'b1, 4095, 4095));
  endtask

  // Register extremes, each followed by random traffic
  task automatic test_register_extremes();
    apply_settings(0, 0, 0, 0, 255);
    run_random(150, 0);
    apply_settings(1023, 1023, 65535, 65535, 0);
    run_random(150, 1);
    apply_settings(0, 1023, 65535, 1, 255);
    run_random(150, 2);
  endtask

  // Random settings; one phase runs with no idling on either side
  task automatic test_random_settings();
    for (int ph = 0; ph < 8; ph++) begin
      apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(1000, 12000),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(1000, 12000),
                     ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20)
                                                 : $urandom_range(0, 255));
      steady = (ph == 3);
      run_random(150, ph % 3);
      steady = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && servo_ch.valid && servo_ch.ready) begin
      if (pending_pulses.size() == 0) begin
        $error("result with no item outstanding: pan %0d tilt %0d",
               servo_ch.pan_pulse, servo_ch.tilt_pulse);
        mismatches++;
      end else begin
        want = pending_pulses.pop_front();
        if (servo_ch.pan_pulse !== want.pan_pulse) begin
          $error("pan_pulse: expected %0d, got %0d", want.pan_pulse, servo_ch.pan_pulse);
          mismatches++;
        end
        if (servo_ch.tilt_pulse !== want.tilt_pulse) begin
          $error("tilt_pulse: expected %0d, got %0d", want.tilt_pulse, servo_ch.tilt_pulse);
          mismatches++;
        end
        if (servo_ch.pan_write !== want.pan_write) begin
          $error("pan_write: expected %0b, got %0b", want.pan_write, servo_ch.pan_write);
          mismatches++;
        end
        if (servo_ch.tilt_write !== want.tilt_write) begin
          $error("tilt_write: expected %0b, got %0b", want.tilt_write, servo_ch.tilt_write);
          mismatches++;
        end
      end
    end
  end

  // Result receiver: ready held for a random run, then a random stall
  initial begin
    int hold;
    servo_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      servo_ch.ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      hold = idle_cycles();
      if (hold > 0) begin
        servo_ch.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
    end
  end

  // Run limit: far beyond the slowest legal run (about 1.2 ms)
  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = pts_pkg::CFG_AIM_X;
    cfg_data           = '0;
    tick_ch.valid      = 1'b0;
    tick_ch.auto_mode  = 1'b0;
    tick_ch.joy_valid  = 1'b0;
    tick_ch.joy_x      = '0;
    tick_ch.joy_y      = '0;
    tick_ch.face_valid = 1'b0;
    tick_ch.face_x     = '0;
    tick_ch.face_y     = '0;
    tick_ch.face_w     = '0;
    tick_ch.face_h     = '0;

    // state after reset
    aim_x         = pts_pkg::AIM_X_RST;
    aim_y         = pts_pkg::AIM_Y_RST;
    pan_gain_r    = pts_pkg::PAN_GAIN_RST;
    tilt_gain_r   = pts_pkg::TILT_GAIN_RST;
    deadband_r    = pts_pkg::DEADBAND_RST;
    pan_now       = PW'(pts_pkg::PULSE_HOME);
    tilt_now      = PW'(pts_pkg::PULSE_HOME);
    pan_last_man  = '0;
    tilt_last_man = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_joystick_edges();
    test_face_deadband();
    test_clamps();
    test_register_extremes();
    test_random_settings();

    // all items sent: wait for the tail, then idle before the final check
    tick_ch.valid = 1'b0;
    waited = 0;
    while (pending_pulses.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_pulses.size() != 0)
      $error("%0d expected results never arrived", pending_pulses.size());

    if (mismatches == 0 && pending_pulses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
